// ===== hdl/fpr_pkg.sv =====
// ----------------------------------------------------------------------------
// fpr_pkg: shared definitions for the framed packet receiver
// Framing byte codes, frame phase codes, event codes and the result record.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam logic [7:0] ByteStart = 8'h02;
  localparam logic [7:0] ByteEnd   = 8'h03;
  localparam logic [7:0] ByteEsc   = 8'h10;

  localparam logic [2:0] PhWait     = 3'd0;
  localparam logic [2:0] PhAddrHi   = 3'd1;
  localparam logic [2:0] PhAddrLo   = 3'd2;
  localparam logic [2:0] PhLength   = 3'd3;
  localparam logic [2:0] PhCommand  = 3'd4;
  localparam logic [2:0] PhPayload  = 3'd5;
  localparam logic [2:0] PhChecksum = 3'd6;
  localparam logic [2:0] PhTrailer  = 3'd7;

  localparam logic [1:0] EvNone   = 2'd0;
  localparam logic [1:0] EvData   = 2'd1;
  localparam logic [1:0] EvAccept = 2'd2;
  localparam logic [1:0] EvReject = 2'd3;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] payload_length;
  } fpr_result_t;

endpackage

// ===== hdl/fpr_deframer.sv =====
// ----------------------------------------------------------------------------
// fpr_deframer: frame state and per-byte decode
// Holds the escape flag, frame phase, checksum and counters, and works out
// the result of one byte combinationally from the current state.
// ----------------------------------------------------------------------------
module fpr_deframer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          rx_byte_i,
  output fpr_pkg::fpr_result_t result_o
);
  import fpr_pkg::*;

  logic       esc_q,   esc_d;
  logic [2:0] phase_q, phase_d;
  logic [7:0] sum_q,   sum_d;
  logic [7:0] len_q,   len_d;
  logic [7:0] cnt_q,   cnt_d;
  logic       consumed;
  logic [7:0] sum_add;
  logic [7:0] cnt_inc;

  assign sum_add = sum_q + rx_byte_i;
  assign cnt_inc = cnt_q + 8'd1;

  always_comb begin
    esc_d    = esc_q;
    phase_d  = phase_q;
    sum_d    = sum_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    consumed = 1'b0;
    result_o = '0;

    if (rx_byte_i == ByteStart) begin
      if (esc_q) begin
        esc_d = 1'b0;
      end else begin
        phase_d  = PhAddrHi;
        sum_d    = '0;
        len_d    = '0;
        cnt_d    = '0;
        consumed = 1'b1;
      end
    end else if (rx_byte_i == ByteEnd) begin
      esc_d = 1'b0;
    end else if (rx_byte_i == ByteEsc) begin
      if (esc_q) begin
        esc_d = 1'b0;
      end else begin
        esc_d    = 1'b1;
        consumed = 1'b1;
      end
    end

    if (!consumed) begin
      case (phase_q)
        PhAddrHi, PhAddrLo, PhCommand: begin
          sum_d   = sum_add;
          phase_d = phase_q + 3'd1;
        end
        PhLength: begin
          len_d   = (rx_byte_i >= 8'd2) ? rx_byte_i - 8'd2 : 8'd0;
          sum_d   = sum_add;
          phase_d = PhCommand;
        end
        PhPayload: begin
          result_o.event_res     = EvData;
          result_o.payload_byte  = rx_byte_i;
          result_o.payload_index = cnt_q;
          cnt_d                  = cnt_inc;
          sum_d                  = sum_add;
          if (cnt_inc >= len_q) begin
            phase_d = PhChecksum;
          end
        end
        PhChecksum: begin
          if (sum_q == rx_byte_i) begin
            phase_d = PhTrailer;
          end else begin
            phase_d            = PhWait;
            result_o.event_res = EvReject;
          end
        end
        PhTrailer: begin
          result_o.event_res = (rx_byte_i == ByteEnd) ? EvAccept : EvReject;
          phase_d            = PhWait;
        end
        default: begin
        end
      endcase
    end

    result_o.payload_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= 1'b0;
      phase_q <= PhWait;
      sum_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
    end else if (take_i) begin
      esc_q   <= esc_d;
      phase_q <= phase_d;
      sum_q   <= sum_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_i |=> $stable(phase_q) && $stable(cnt_q) && $stable(esc_q))
    else $error("deframer state changed without a transaction");

  a_start_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && rx_byte_i == ByteStart && !esc_q |=> phase_q == PhAddrHi && cnt_q == 8'd0)
    else $error("unescaped start did not restart the frame");

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.event_res == EvData |-> result_o.payload_index <= result_o.payload_length)
    else $error("payload index beyond expected length");
`endif

endmodule

// ===== hdl/framed_packet_receiver_top.sv =====
// ----------------------------------------------------------------------------
// framed_packet_receiver_top: deframer for escaped, checksummed byte packets
//
// Each received byte enters on the input channel (in_valid_i, in_stall_o,
// rx_byte_i) and yields exactly one result transaction on the output
// channel (out_valid_o, out_stall_i): an event code with payload byte,
// payload index and expected payload length.
// A byte is held in an input register, decoded against the frame state,
// and its result is loaded into the output register, from which it is
// presented on the output channel until the receiver takes it.
// One byte is accepted every cycle while the output side takes results;
// the single decode stage between the two registers sets that figure.
// When the receiver stalls, the output register holds its result, the input
// register fills, and in_stall_o then rises until the result is taken.
// Reset clears both valid flags and returns the frame state to waiting for
// a start byte with no escape pending.
// ----------------------------------------------------------------------------
module framed_packet_receiver_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] event_res_o,
  output logic [7:0] payload_byte_o,
  output logic [7:0] payload_index_o,
  output logic [7:0] payload_length_o
);
  import fpr_pkg::*;

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s2_valid_q;
  fpr_result_t s2_res_q;
  fpr_result_t dec_res;
  logic        s2_free;
  logic        s1_move;
  logic        in_take;

  assign s2_free    = !s2_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && s2_free;
  assign in_stall_o = s1_valid_q && !s2_free;
  assign in_take    = in_valid_i && !in_stall_o;

  fpr_deframer u_deframer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (s1_move),
    .rx_byte_i (s1_byte_q),
    .result_o  (dec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= rx_byte_i;
    end
    if (s1_move) begin
      s2_res_q <= dec_res;
    end
  end

  assign out_valid_o      = s2_valid_q;
  assign event_res_o      = s2_res_q.event_res;
  assign payload_byte_o   = s2_res_q.payload_byte;
  assign payload_index_o  = s2_res_q.payload_index;
  assign payload_length_o = s2_res_q.payload_length;

`ifndef NO_ASSERTIONS
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s2_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_free |=> s1_valid_q && $stable(s1_byte_q))
    else $error("held byte lost while output stalled");

  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EvData |-> payload_byte_o == 8'd0 && payload_index_o == 8'd0)
    else $error("payload fields set on a non-data event");
`endif

endmodule
